FILE: rtl/srec_pkg.sv
// Package: shared types, codes and decode helpers of the S-record line parser.
`default_nettype none

package srec_pkg;

	// Parse position within one record line
	typedef enum logic [2:0] {
		PH_WAIT  = 3'd0,
		PH_TYPE  = 3'd1,
		PH_COUNT = 3'd2,
		PH_ADDR  = 3'd3,
		PH_DATA  = 3'd4,
		PH_CKS   = 3'd5,
		PH_DONE  = 3'd6,
		PH_ERR   = 3'd7
	} phase_t;

	// Line status reported in a summary word
	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_SYNTAX = 3'd1,
		ST_S4     = 3'd2,
		ST_CKS    = 3'd3,
		ST_TRAIL  = 3'd4
	} line_status_t;

	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [7:0] CHAR_S    = 8'h53;
	localparam logic [7:0] CHAR_NUL  = 8'h00;
	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_FF   = 8'hFF;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	localparam logic [3:0] TYPE_S4 = 4'd4;

	// One result word
	typedef struct packed {
		logic         kind;
		logic [3:0]   record_type;
		logic [7:0]   byte_count;
		logic [31:0]  address;
		logic [7:0]   data_byte;
		logic [7:0]   data_index;
		logic [7:0]   checksum;
		line_status_t status;
	} result_t;

	// Address length in bytes for a record type
	function automatic logic [2:0] addr_len(input logic [3:0] rtype);
		logic [2:0] len;
		case (rtype)
			4'd2, 4'd6, 4'd8: len = 3'd3;
			4'd3, 4'd7:       len = 3'd4;
			default:          len = 3'd2;
		endcase
		return len;
	endfunction

	// Hex digit decode: bit 4 flags a non-hex character
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			v = {1'b0, c[3:0] + 4'd9};
		end else begin
			v = 5'h10;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/srec_if.sv
// Interfaces: character input channel and result output channel.
`default_nettype none

interface srec_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

interface srec_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [3:0]  record_type;
	logic [7:0]  byte_count;
	logic [31:0] address;
	logic [7:0]  data_byte;
	logic [7:0]  data_index;
	logic [7:0]  checksum;
	logic [2:0]  status;

	modport source (output valid, output kind, output record_type, output byte_count,
		output address, output data_byte, output data_index, output checksum,
		output status, input ready);
	modport sink   (input valid, input kind, input record_type, input byte_count,
		input address, input data_byte, input data_index, input checksum,
		input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/srec_line_parser.sv
// Motorola S-record line parser: one character in, data bytes and line summaries out.
//
// Usage:
//   in_ch carries one ASCII character per word. out_ch carries result words:
//   kind 0 is a decoded data byte, emitted when its second hex digit arrives;
//   kind 1 is the end-of-line summary emitted at a CR, LF, NUL or 0xFF, with
//   status ok, syntax, S4 unsupported, checksum mismatch or trailing chars.
//   A terminator at the start of a line produces no word.
// Throughput:
//   One character is taken every cycle while in_ch.ready is high. A result
//   is registered in the output register, or in the skid entry if out_ch stalls;
//   the parse state update is a single step of the line state machine per character.
// Stall behavior:
//   An output register plus one skid entry sit behind the parser, so input
//   keeps flowing while one result waits; in_ch.ready drops only while the
//   skid entry is occupied.
// Reset:
//   arst_n clears the line state (waiting for 'S') and empties both output
//   entries; no result is pending after reset.
`default_nettype none

module srec_line_parser (
	input  wire           clk,
	input  wire           arst_n,
	srec_char_if.sink     in_ch,
	srec_result_if.source out_ch
);
	import srec_pkg::*;

	// Line state
	phase_t       phase_q,  phase_d;
	logic [3:0]   digit_count_q, digit_count_d;
	logic [3:0]   type_q,   type_d;
	logic [7:0]   count_q,  count_d;
	logic [31:0]  addr_q,   addr_d;
	logic [7:0]   sum_q,    sum_d;
	logic [7:0]   left_q,   left_d;
	logic [7:0]   pos_q,    pos_d;
	logic [3:0]   hi_q,     hi_d;
	logic [7:0]   cks_q,    cks_d;
	line_status_t status_q, status_d;

	// Output register and skid entry
	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;

	logic       accept, push, pop;
	logic       has_result;
	result_t    res;
	logic [7:0] c;
	logic       term;
	logic [4:0] hex;
	logic [2:0] alen;
	logic [3:0] dc_inc;
	logic [31:0] addr_sh;
	logic [7:0] b;

	assign c      = in_ch.char_code;
	assign term   = (c == CHAR_NUL) || (c == CHAR_CR) || (c == CHAR_LF) || (c == CHAR_FF);
	assign hex    = hex_decode(c);
	assign alen   = addr_len(type_q);
	assign dc_inc = digit_count_q + 4'd1;
	assign addr_sh = {addr_q[27:0], hex[3:0]};
	assign b      = {hi_q, hex[3:0]};

	assign in_ch.ready = !skid_valid_q;
	assign accept      = in_ch.valid && in_ch.ready;
	assign pop         = out_valid_q && out_ch.ready;
	assign push        = accept && has_result;

	// Next line state and result for the current character
	always_comb begin
		phase_d       = phase_q;
		digit_count_d = digit_count_q;
		type_d        = type_q;
		count_d       = count_q;
		addr_d        = addr_q;
		sum_d         = sum_q;
		left_d        = left_q;
		pos_d         = pos_q;
		hi_d          = hi_q;
		cks_d         = cks_q;
		status_d      = status_q;
		has_result    = 1'b0;
		res.kind        = KIND_DATA;
		res.record_type = type_q;
		res.byte_count  = count_q;
		res.address     = addr_q;
		res.data_byte   = 8'd0;
		res.data_index  = pos_q;
		res.checksum    = 8'd0;
		res.status      = ST_OK;

		if (term) begin
			// End of line: summarize and clear, except on an empty line
			if (phase_q != PH_WAIT) begin
				has_result   = 1'b1;
				res.kind     = KIND_SUMMARY;
				res.checksum = cks_q;
				res.status   = (phase_q == PH_DONE || phase_q == PH_ERR) ? status_q : ST_SYNTAX;
				phase_d       = PH_WAIT;
				digit_count_d = 4'd0;
				type_d        = 4'd0;
				count_d       = 8'd0;
				addr_d        = 32'd0;
				sum_d         = 8'd0;
				left_d        = 8'd0;
				pos_d         = 8'd0;
				hi_d          = 4'd0;
				cks_d         = 8'd0;
				status_d      = ST_OK;
			end
		end else begin
			unique case (phase_q)
				PH_WAIT: begin
					if (c == CHAR_S) begin
						phase_d = PH_TYPE;
					end else begin
						phase_d  = PH_ERR;
						status_d = ST_SYNTAX;
					end
				end
				PH_TYPE: begin
					if (c < CHAR_ZERO || c > CHAR_NINE) begin
						phase_d  = PH_ERR;
						status_d = ST_SYNTAX;
					end else begin
						type_d = c[3:0];
						if (c[3:0] == TYPE_S4) begin
							phase_d  = PH_ERR;
							status_d = ST_S4;
						end else begin
							digit_count_d = 4'd0;
							phase_d       = PH_COUNT;
						end
					end
				end
				PH_DONE: begin
					phase_d  = PH_ERR;
					status_d = ST_TRAIL;
				end
				PH_ERR: begin
					phase_d = PH_ERR;
				end
				PH_ADDR: begin
					// Shift in an address digit; add each completed byte to the sum
					if (hex[4]) begin
						phase_d  = PH_ERR;
						status_d = ST_SYNTAX;
					end else begin
						addr_d        = addr_sh;
						digit_count_d = dc_inc;
						if (!dc_inc[0]) begin
							sum_d = sum_q + addr_sh[7:0];
						end
						if (dc_inc >= {alen, 1'b0}) begin
							digit_count_d = 4'd0;
							phase_d       = (left_q != 8'd0) ? PH_DATA : PH_CKS;
						end
					end
				end
				PH_COUNT, PH_DATA, PH_CKS: begin
					if (hex[4]) begin
						phase_d  = PH_ERR;
						status_d = ST_SYNTAX;
					end else if (digit_count_q == 4'd0) begin
						hi_d          = hex[3:0];
						digit_count_d = 4'd1;
					end else begin
						digit_count_d = 4'd0;
						if (phase_q == PH_COUNT) begin
							count_d = b;
							if (b < ({5'd0, alen} + 8'd1)) begin
								phase_d  = PH_ERR;
								status_d = ST_SYNTAX;
							end else begin
								sum_d   = b;
								left_d  = b - {5'd0, alen} - 8'd1;
								addr_d  = 32'd0;
								phase_d = PH_ADDR;
							end
						end else if (phase_q == PH_DATA) begin
							// Emit the data byte
							has_result    = 1'b1;
							res.data_byte = b;
							sum_d  = sum_q + b;
							pos_d  = pos_q + 8'd1;
							left_d = left_q - 8'd1;
							if (left_q == 8'd1) begin
								phase_d = PH_CKS;
							end
						end else begin
							cks_d = b;
							if (~sum_q != b) begin
								status_d = ST_CKS;
							end
							phase_d = PH_DONE;
						end
					end
				end
				default: begin
					phase_d = PH_ERR;
				end
			endcase
		end
	end

	// Advance the line state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_WAIT;
			digit_count_q <= 4'd0;
			type_q        <= 4'd0;
			count_q       <= 8'd0;
			addr_q        <= 32'd0;
			sum_q         <= 8'd0;
			left_q        <= 8'd0;
			pos_q         <= 8'd0;
			hi_q          <= 4'd0;
			cks_q         <= 8'd0;
			status_q      <= ST_OK;
		end else if (accept) begin
			phase_q       <= phase_d;
			digit_count_q <= digit_count_d;
			type_q        <= type_d;
			count_q       <= count_d;
			addr_q        <= addr_d;
			sum_q         <= sum_d;
			left_q        <= left_d;
			pos_q         <= pos_d;
			hi_q          <= hi_d;
			cks_q         <= cks_d;
			status_q      <= status_d;
		end
	end

	// Output and skid valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output and skid payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.kind        = out_q.kind;
	assign out_ch.record_type = out_q.record_type;
	assign out_ch.byte_count  = out_q.byte_count;
	assign out_ch.address     = out_q.address;
	assign out_ch.data_byte   = out_q.data_byte;
	assign out_ch.data_index  = out_q.data_index;
	assign out_ch.checksum    = out_q.checksum;
	assign out_ch.status      = out_q.status;

`ifndef ASSERT_OFF
	// Skid entry holds a word only behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry occupied with output register empty");

	// A data word never carries an error status
	a_data_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == KIND_DATA) |-> (out_q.status == ST_OK))
		else $error("data word with nonzero status");

	// A summary returns the parser to the start of a line
	a_summary_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(push && res.kind == KIND_SUMMARY) |=> (phase_q == PH_WAIT && pos_q == 8'd0))
		else $error("line state not cleared after summary");

	// Data phase is only entered with bytes remaining
	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (left_q != 8'd0))
		else $error("data phase with no bytes left");
`endif

endmodule

`default_nettype wire
